[hw/rtl/multi_key_debounce_fsm_core_defines.svh]
// assertion macros shared by the debounce block checkers
// expects clk and rst_n in the scope where a macro is used
`ifndef MULTI_KEY_DEBOUNCE_FSM_CORE_DEFINES_SVH
`define MULTI_KEY_DEBOUNCE_FSM_CORE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define MKD_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define MKD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/mkd_pkg.sv]
// shared types and constants for the multi-key debounce block
// no dependencies
package mkd_pkg;

  localparam int NUM_KEYS_DEF = 4;
  localparam int MASK_W       = 4;
  localparam int TIME_W       = 32;
  localparam int DT_W         = 16;
  localparam int CFG_IDX_W    = 1;
  localparam int CFG_DATA_W   = 16;

  localparam logic [DT_W-1:0] DT_RESET = 16'd20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE_TIME = 1'b0,
    CFG_ENABLE        = 1'b1
  } cfg_idx_t;

  typedef enum logic [1:0] {
    PH_RELEASED   = 2'd0,
    PH_PRESS_DB   = 2'd1,
    PH_PRESSED    = 2'd2,
    PH_RELEASE_DB = 2'd3
  } key_phase_t;

  typedef struct packed {
    logic confirm;
    logic held;
  } lane_res_t;

endpackage

[hw/rtl/mkd_if.sv]
// valid/ready channels for polls and results
// depends on mkd_pkg
interface mkd_in_if;
  import mkd_pkg::*;

  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] pending_mask;
  logic [MASK_W-1:0] pressed_mask;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, pending_mask, pressed_mask, now_ms, input ready);
  modport sink   (input valid, pending_mask, pressed_mask, now_ms, output ready);
  modport mon    (input valid, ready, pending_mask, pressed_mask, now_ms);
endinterface

interface mkd_out_if;
  import mkd_pkg::*;

  logic              valid;
  logic              ready;
  logic [MASK_W-1:0] confirmed_mask;
  logic [MASK_W-1:0] held_mask;

  modport source (output valid, confirmed_mask, held_mask, input ready);
  modport sink   (input valid, confirmed_mask, held_mask, output ready);
  modport mon    (input valid, ready, confirmed_mask, held_mask);
endinterface

[hw/rtl/multi_key_debounce_fsm_core.sv]
// latency: a result is valid the cycle after its poll transfers
// throughput: one poll per cycle unless stalled; each key lane does one
//   compare and one transition per cycle, and the output register frees as it is taken
// reset (synchronous, rst_n low): all keys released, debounce time 20,
//   block disabled, no result pending
module multi_key_debounce_fsm_core #(
  parameter int NUM_KEYS = mkd_pkg::NUM_KEYS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  mkd_in_if.sink                           in_ch,
  mkd_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [mkd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mkd_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import mkd_pkg::*;

  logic [DT_W-1:0]               debounce_time_r;
  logic                          enable_r;
  logic                          in_ready;
  logic                          step;
  mkd_pkg::lane_res_t [NUM_KEYS-1:0] lane_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_time_r <= DT_RESET;
      enable_r        <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_DEBOUNCE_TIME: debounce_time_r <= cfg_wdata[DT_W-1:0];
        CFG_ENABLE:        enable_r        <= cfg_wdata[0];
      endcase
    end
  end

  // machines only move on a transfer while enabled
  assign step        = in_ch.valid && in_ready && enable_r;
  assign in_ch.ready = in_ready;

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    logic pend_k, lvl_k;
    if (k < MASK_W) begin : g_in
      assign pend_k = in_ch.pending_mask[k];
      assign lvl_k  = in_ch.pressed_mask[k];
    end else begin : g_zero
      assign pend_k = 1'b0;
      assign lvl_k  = 1'b0;
    end

    mkd_lane u_lane (
      .clk           (clk),
      .rst_n         (rst_n),
      .step          (step),
      .pend          (pend_k),
      .pressed       (lvl_k),
      .now_ms        (in_ch.now_ms),
      .debounce_time (debounce_time_r),
      .res           (lane_res[k])
    );
  end

  mkd_merge #(
    .NUM_KEYS (NUM_KEYS)
  ) u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_ch.valid),
    .in_ready      (in_ready),
    .lane_res      (lane_res),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_confirmed (out_ch.confirmed_mask),
    .out_held      (out_ch.held_mask)
  );

endmodule

[hw/rtl/mkd_lane.sv]
// one key's debounce state machine with its phase start time
// depends on mkd_pkg
module mkd_lane (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  logic                      pend,
  input  logic                      pressed,
  input  logic [mkd_pkg::TIME_W-1:0] now_ms,
  input  logic [mkd_pkg::DT_W-1:0]   debounce_time,
  output mkd_pkg::lane_res_t         res
);
  import mkd_pkg::*;

  key_phase_t        phase_r, phase_nxt;
  logic [TIME_W-1:0] start_r, start_nxt;
  logic [TIME_W-1:0] diff;
  logic              elapsed;

  // wrapping difference, compared unsigned
  assign diff    = now_ms - start_r;
  assign elapsed = diff >= {{(TIME_W-DT_W){1'b0}}, debounce_time};

  always_comb begin
    phase_nxt = phase_r;
    start_nxt = start_r;
    if (step) begin
      unique case (phase_r)
        PH_RELEASED: begin
          if (pend) begin
            phase_nxt = PH_PRESS_DB;
            start_nxt = now_ms;
          end
        end
        PH_PRESS_DB: begin
          if (elapsed) begin
            phase_nxt = pressed ? PH_PRESSED : PH_RELEASED;
          end
        end
        PH_PRESSED: begin
          if (!pressed) begin
            phase_nxt = PH_RELEASE_DB;
            start_nxt = now_ms;
          end
        end
        PH_RELEASE_DB: begin
          if (pressed) begin
            phase_nxt = PH_PRESSED;
          end else if (elapsed) begin
            phase_nxt = PH_RELEASED;
          end
        end
      endcase
    end
  end

  always_comb begin
    res.confirm = step && (phase_r == PH_PRESS_DB) && elapsed && pressed;
    res.held    = (phase_nxt == PH_PRESSED) || (phase_nxt == PH_RELEASE_DB);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_RELEASED;
    end else begin
      phase_r <= phase_nxt;
    end
  end

  // start time is only read after a phase that wrote it
  always_ff @(posedge clk) begin
    start_r <= start_nxt;
  end

endmodule

[hw/rtl/mkd_merge.sv]
// gathers lane results into the result masks and holds the output register
// depends on mkd_pkg
module mkd_merge #(
  parameter int NUM_KEYS = mkd_pkg::NUM_KEYS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  mkd_pkg::lane_res_t [NUM_KEYS-1:0]  lane_res,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [mkd_pkg::MASK_W-1:0]         out_confirmed,
  output logic [mkd_pkg::MASK_W-1:0]         out_held
);
  import mkd_pkg::*;

  logic              valid_r, valid_nxt;
  logic [MASK_W-1:0] conf_r, held_r;
  logic [MASK_W-1:0] conf_w, held_w;
  logic              load;

  // keys past the field width are dropped, missing keys read as zero
  for (genvar k = 0; k < MASK_W; k++) begin : g_bit
    if (k < NUM_KEYS) begin : g_key
      assign conf_w[k] = lane_res[k].confirm;
      assign held_w[k] = lane_res[k].held;
    end else begin : g_none
      assign conf_w[k] = 1'b0;
      assign held_w[k] = 1'b0;
    end
  end

  assign in_ready  = !valid_r || out_ready;
  assign load      = in_valid && in_ready;
  assign valid_nxt = load || (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      conf_r <= conf_w;
      held_r <= held_w;
    end
  end

  assign out_valid     = valid_r;
  assign out_confirmed = conf_r;
  assign out_held      = held_r;

endmodule

[hw/rtl/mkd_checker.sv]
// port-level checks for the debounce block, bound to the top level
// depends on mkd_pkg, mkd_if and the assertion macro header
`include "multi_key_debounce_fsm_core_defines.svh"

module mkd_checker (
  input logic        clk,
  input logic        rst_n,
  mkd_in_if.sink     in_ch,
  mkd_out_if.source  out_ch
);
  import mkd_pkg::*;

  // a confirmed press always leaves the key held
  `MKD_ASSERT_SAME(a_conf_held, out_ch.valid, (out_ch.confirmed_mask & ~out_ch.held_mask) == '0, "confirmed key not held")
  // every poll transfer yields a result on the next cycle
  `MKD_ASSERT_NEXT(a_poll_result, in_ch.valid && in_ch.ready, out_ch.valid, "poll without result")
  // a stalled result blocks new polls
  `MKD_ASSERT_SAME(a_stall_block, out_ch.valid && !out_ch.ready, !in_ch.ready, "poll taken over stalled result")
  // with no result pending the block takes polls
  `MKD_ASSERT_SAME(a_idle_ready, !out_ch.valid, in_ch.ready, "idle block refuses poll")
  // stalled result holds its payload
  `MKD_ASSERT_NEXT(a_out_hold, out_ch.valid && !out_ch.ready, out_ch.valid && $stable(out_ch.confirmed_mask) && $stable(out_ch.held_mask), "stalled result changed")

endmodule

bind multi_key_debounce_fsm_core mkd_checker u_mkd_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .in_ch  (in_ch),
  .out_ch (out_ch)
);

[tb/tb_multi_key_debounce_fsm_core.sv]
// testbench for multi_key_debounce_fsm_core: directed and random polls, with the
// expected confirm and held masks computed per poll and compared on each result
// depends on mkd_pkg, mkd_if and the core
module tb_multi_key_debounce_fsm_core;
  import mkd_pkg::*;

  localparam int CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [MASK_W-1:0] confirmed;
    logic [MASK_W-1:0] held;
  } key_masks_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  mkd_in_if in_ch();
  mkd_out_if out_ch();

  multi_key_debounce_fsm_core uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // shadow of the block: registers and per-key machines
  logic [DT_W-1:0] db_time = DT_RESET;
  logic keys_enabled = 1'b0;
  key_phase_t key_state [MASK_W] = '{default: PH_RELEASED};
  logic [TIME_W-1:0] key_stamp [MASK_W] = '{default: '0};

  key_masks_t expected_masks [$];
  int mismatches = 0;
  int unsigned cycle_count = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  int unsigned rx_hold_left = 0;

  // stimulus-side pin model for random polls
  logic [MASK_W-1:0] pin_down = '0;
  logic [TIME_W-1:0] tick_ms = '0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic key_masks_t step_key_machines(logic [MASK_W-1:0] pend,
                                                   logic [MASK_W-1:0] lvl,
                                                   logic [TIME_W-1:0] now);
    key_masks_t r;
    logic [TIME_W-1:0] age;
    logic elapsed;
    r = '0;
    if (keys_enabled) begin
      for (int k = 0; k < MASK_W; k++) begin
        age = now - key_stamp[k];
        elapsed = (age >= TIME_W'(db_time));
        case (key_state[k])
          PH_RELEASED: begin
            if (pend[k]) begin
              key_stamp[k] = now;
              key_state[k] = PH_PRESS_DB;
            end
          end
          PH_PRESS_DB: begin
            if (elapsed) begin
              if (lvl[k]) begin
                key_state[k] = PH_PRESSED;
                r.confirmed[k] = 1'b1;
              end else begin
                key_state[k] = PH_RELEASED;
              end
            end
          end
          PH_PRESSED: begin
            if (!lvl[k]) begin
              key_stamp[k] = now;
              key_state[k] = PH_RELEASE_DB;
            end
          end
          default: begin
            if (lvl[k]) key_state[k] = PH_PRESSED;
            else if (elapsed) key_state[k] = PH_RELEASED;
          end
        endcase
      end
    end
    for (int k = 0; k < MASK_W; k++)
      r.held[k] = (key_state[k] == PH_PRESSED) || (key_state[k] == PH_RELEASE_DB);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("mismatch %s: expected %0h got %0h (cycle %0d)", what, want, got, cycle_count);
    mismatches++;
  endtask

  // result side: check each transfer, then pick ready for the next cycle
  initial begin
    key_masks_t want;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready) begin
        if (expected_masks.size() == 0) begin
          report_mismatch("unexpected result", 32'h0,
                          32'({out_ch.confirmed_mask, out_ch.held_mask}));
        end else begin
          want = expected_masks.pop_front();
          if (out_ch.confirmed_mask !== want.confirmed)
            report_mismatch("confirmed_mask", 32'(want.confirmed),
                            32'(out_ch.confirmed_mask));
          if (out_ch.held_mask !== want.held)
            report_mismatch("held_mask", 32'(want.held), 32'(out_ch.held_mask));
        end
      end
      if (rx_hold_left > 0) begin
        out_ch.ready <= 1'b0;
        rx_hold_left--;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_poll(logic [MASK_W-1:0] pend, logic [MASK_W-1:0] lvl,
                           logic [TIME_W-1:0] now);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.pending_mask <= pend;
    in_ch.pressed_mask <= lvl;
    in_ch.now_ms <= now;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_masks.push_back(step_key_machines(pend, lvl, now));
  endtask

  task automatic wait_all_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_masks.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DEBOUNCE_TIME: db_time = val[DT_W-1:0];
      CFG_ENABLE:        keys_enabled = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // pins toggle now and then with an edge mark, plus some edge and level noise
  task automatic send_random_poll();
    logic [MASK_W-1:0] pend;
    logic [MASK_W-1:0] lvl;
    int unsigned step;
    int unsigned span;
    pend = '0;
    for (int k = 0; k < MASK_W; k++) begin
      if ($urandom_range(99) < 12) begin
        pin_down[k] = ~pin_down[k];
        if (pin_down[k] && $urandom_range(9) != 0) pend[k] = 1'b1;
      end
    end
    lvl = pin_down;
    if ($urandom_range(19) == 0) pend ^= MASK_W'($urandom);
    if ($urandom_range(19) == 0) lvl ^= MASK_W'($urandom);
    span = 32'(db_time);
    case ($urandom_range(9))
      0: step = $urandom;
      1, 2, 3: step = $urandom_range(span * 2 + 2);
      default: step = $urandom_range(span / 3 + 1);
    endcase
    tick_ms = tick_ms + step;
    send_poll(pend, lvl, tick_ms);
  endtask

  task automatic test_disabled_after_reset();
    send_poll(4'hF, 4'hF, 32'hFFFF_FFFF);
    send_poll(4'hF, 4'h0, 32'h0);
  endtask

  task automatic test_zero_debounce();
    wait_all_results();
    write_reg(CFG_DEBOUNCE_TIME, 16'd0);
    write_reg(CFG_ENABLE, 16'd1);
    send_poll(4'hF, 4'hF, 32'hFFFF_FFFF);
    // confirm across the time wrap; edge marks on pressed keys are ignored
    send_poll(4'hF, 4'hF, 32'h0);
    send_poll(4'hF, 4'h0, 32'h0);
    send_poll(4'h0, 4'h0, 32'h0);
    send_poll(4'h3, 4'h0, 32'd5);
    send_poll(4'h0, 4'h0, 32'd5);
  endtask

  task automatic test_wrap_and_mixed();
    wait_all_results();
    write_reg(CFG_DEBOUNCE_TIME, 16'd20);
    send_poll(4'hF, 4'hF, 32'hFFFF_FFF0);
    send_poll(4'h0, 4'hF, 32'd3);
    send_poll(4'h0, 4'h5, 32'd4);
    send_poll(4'hA, 4'hF, 32'd5);
  endtask

  task automatic test_release_bounce();
    send_poll(4'h0, 4'h4, 32'd6);
    send_poll(4'h0, 4'h5, 32'd7);
    send_poll(4'h0, 4'h0, 32'd8);
    send_poll(4'h0, 4'h0, 32'd28);
  endtask

  task automatic test_long_debounce();
    wait_all_results();
    write_reg(CFG_DEBOUNCE_TIME, 16'hFFFF);
    send_poll(4'h9, 4'h9, 32'd100);
    send_poll(4'h0, 4'h9, 32'd100 + 32'd65534);
    send_poll(4'h0, 4'h9, 32'd100 + 32'd65535);
  endtask

  task automatic test_disable_mid_press();
    wait_all_results();
    write_reg(CFG_ENABLE, 16'd0);
    send_poll(4'h6, 4'h0, 32'd0);
    wait_all_results();
    write_reg(CFG_ENABLE, 16'd1);
  endtask

  task automatic test_random_traffic();
    logic [DT_W-1:0] dt_choices [6];
    dt_choices = '{16'd0, 16'd1, 16'd3, 16'd20, 16'hFFFF, 16'd0};
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin tx_idle_pct = 37; rx_idle_pct = 58; end
        1: begin tx_idle_pct = 58; rx_idle_pct = 37; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      dt_choices[5] = DT_W'($urandom_range(65535));
      for (int seg = 0; seg < 6; seg++) begin
        wait_all_results();
        write_reg(CFG_DEBOUNCE_TIME, dt_choices[seg]);
        write_reg(CFG_ENABLE, 16'd1);
        if ($urandom_range(3) == 0) tick_ms = 32'hFFFF_FFFF - $urandom_range(200000);
        repeat (80) send_random_poll();
      end
      // ignored polls while disabled
      wait_all_results();
      write_reg(CFG_ENABLE, 16'd0);
      repeat (10) send_random_poll();
    end
    wait_all_results();
    write_reg(CFG_DEBOUNCE_TIME, 16'd20);
    write_reg(CFG_ENABLE, 16'd1);
  endtask

  task automatic test_output_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold_left = 300;
    repeat (40) send_random_poll();
  endtask

  task automatic test_sender_pause();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (20) send_random_poll();
    wait_all_results();
    repeat (20) send_random_poll();
  endtask

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_DEBOUNCE_TIME;
    cfg_wdata <= '0;
    in_ch.valid <= 1'b0;
    in_ch.pending_mask <= '0;
    in_ch.pressed_mask <= '0;
    in_ch.now_ms <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    tx_idle_pct = 37;
    rx_idle_pct = 58;
    test_disabled_after_reset();
    test_zero_debounce();
    test_wrap_and_mixed();
    test_release_bounce();
    test_long_debounce();
    test_disable_mid_press();
    test_random_traffic();
    test_output_backpressure();
    test_sender_pause();
    wait_all_results();
    repeat (5) @(posedge clk);
    if (expected_masks.size() != 0)
      report_mismatch("results missing", 32'(expected_masks.size()), 32'h0);
    if (mismatches == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/mkd_pkg.sv
hw/rtl/mkd_if.sv
hw/rtl/mkd_lane.sv
hw/rtl/mkd_merge.sv
hw/rtl/multi_key_debounce_fsm_core.sv
hw/rtl/mkd_checker.sv
tb/tb_multi_key_debounce_fsm_core.sv
